// ===== src/lodsel_pkg.sv =====
package lodsel_pkg;

  // sizes of the level table
  localparam int MAX_LEVELS  = 4;
  localparam int MAX_THRESH  = 4;
  localparam int LVL_W       = $clog2(MAX_LEVELS);
  localparam int CNT_W       = 3;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_W      = $clog2(NUM_AXES);
  localparam int STORE_DEPTH = MAX_LEVELS * NUM_AXES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // arithmetic widths
  localparam int COORD_W = 32;
  localparam int THR_W   = 31;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SCALE_W = ACC_W + 7;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LEVEL_COUNT     = 3'd0;
  localparam cfg_idx_t REG_THRESHOLD_COUNT = 3'd1;
  localparam cfg_idx_t REG_THRESHOLD_ZERO  = 3'd2;
  localparam cfg_idx_t REG_THRESHOLD_ONE   = 3'd3;
  localparam cfg_idx_t REG_THRESHOLD_TWO   = 3'd4;
  localparam cfg_idx_t REG_THRESHOLD_THREE = 3'd5;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_LEVEL,
    ST_THRESH,
    ST_TMUL,
    ST_SCALE,
    ST_CMP
  } state_t;

endpackage

// ===== src/lodsel_ram.sv =====
module lodsel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lod_level_select_hysteresis_unit.sv =====
// level-of-detail selector with hysteresis
//
// input channel: a word is taken at a clock edge with start high and busy low.
//   in_action write: stores one level's box corners (in_first_* low corner,
//   in_second_* high corner) and sets its valid mark, or clears the mark when
//   in_box_present is low. no result word.
//   in_action select: in_first_* is the eye, in_second_* the object origin.
//   exactly one result word follows on out_valid.
// result channel: out_valid is high for one cycle with out_chosen_level and
//   out_none_chosen; the receiver cannot stall, so nothing ever backs up.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
//   the user must write it only while idle; the block does not enforce this.
// busy: a write with box present keeps busy high while it stores one corner
//   axis per cycle on the single write port of the box stores; a clearing
//   write leaves busy low. a select forms the eye-to-origin distance, then
//   per level visited tests the box distance (or the origin distance with
//   no box) against its threshold; the shared 32x32 multiplier squares one
//   value per step. result strobe in the first cycle with busy low. with no
//   levels or no thresholds the result comes the cycle after the start.
// reset: box valid marks, previous choice, counts and thresholds all clear.
module lod_level_select_hysteresis_unit
  import lodsel_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_action,
  input  logic [LVL_W-1:0]          in_level_index,
  input  logic                      in_box_present,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_first_z,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  input  logic signed [COORD_W-1:0] in_second_z,
  // result channel
  output logic                      out_valid,
  output logic [LVL_W-1:0]          out_chosen_level,
  output logic                      out_none_chosen,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    level_count_r, level_count_nxt;
  logic [CNT_W-1:0]    threshold_count_r, threshold_count_nxt;
  logic [THR_W-1:0]    thr_r [MAX_THRESH];
  logic [THR_W-1:0]    thr_nxt [MAX_THRESH];
  logic [MAX_LEVELS-1:0] box_valid_r, box_valid_nxt;
  logic [LVL_W-1:0]    last_level_r, last_level_nxt;
  logic                last_valid_r, last_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AXIS_W-1:0]   ax_r, ax_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic                origin_r, origin_nxt;

  // payload
  logic signed [COORD_W-1:0] first_r [NUM_AXES];
  logic signed [COORD_W-1:0] first_nxt [NUM_AXES];
  logic signed [COORD_W-1:0] second_r [NUM_AXES];
  logic signed [COORD_W-1:0] second_nxt [NUM_AXES];
  logic [LVL_W-1:0]    wr_level_r, wr_level_nxt;
  logic [COORD_W-1:0]  op_r, op_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W-1:0]    d_origin_r, d_origin_nxt;
  logic [SCALE_W-1:0]  lhs_r, lhs_nxt;
  logic [SCALE_W-1:0]  rhs_r, rhs_nxt;
  logic [LVL_W-1:0]    out_level_r, out_level_nxt;
  logic                out_none_r, out_none_nxt;

  // box stores
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [COORD_W-1:0]  low_q, high_q;

  // decode
  logic              accept;
  logic [CNT_W-1:0]  n_lvl, thr_lim, lim;
  logic [LVL_W-1:0]  last_idx;
  logic              last_ax, pass, lvl_last, widen;

  // datapath terms
  logic [COORD_W:0]    e_x, f_x, s_x, lo_x, hi_x;
  logic [COORD_W:0]    below_d, above_d, org_fs, org_sf;
  logic [COORD_W-1:0]  diff_op;
  logic [PROD_W-1:0]   sq;
  logic [SCALE_W-1:0]  aq, tq;

  function automatic logic [STORE_AW-1:0] store_addr(input logic [LVL_W-1:0] lv,
                                                     input logic [AXIS_W-1:0] ax);
    store_addr = STORE_AW'(lv) * STORE_AW'(NUM_AXES) + STORE_AW'(ax);
  endfunction

  lodsel_ram #(.WIDTH(COORD_W), .DEPTH(STORE_DEPTH)) u_low_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (first_r[ax_r]),
    .raddr (ram_raddr),
    .rdata (low_q)
  );

  lodsel_ram #(.WIDTH(COORD_W), .DEPTH(STORE_DEPTH)) u_high_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (second_r[ax_r]),
    .raddr (ram_raddr),
    .rdata (high_q)
  );

  assign ram_we    = (state_r == ST_WRITE);
  assign ram_waddr = store_addr(wr_level_r, ax_r);
  assign ram_raddr = store_addr(lvl_r, ax_r);

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // level and threshold limits, clamped
  assign n_lvl    = (level_count_r > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : level_count_r;
  assign thr_lim  = (threshold_count_r > CNT_W'(MAX_THRESH)) ? CNT_W'(MAX_THRESH)
                                                             : threshold_count_r;
  assign lim      = (thr_lim > n_lvl) ? n_lvl : thr_lim;
  assign last_idx = LVL_W'(n_lvl - CNT_W'(1));

  assign last_ax  = (ax_r == AXIS_W'(NUM_AXES - 1));
  assign pass     = (lhs_r <= rhs_r);
  assign lvl_last = ((CNT_W'(lvl_r) + CNT_W'(1)) == lim);
  assign widen    = last_valid_r && (last_level_r <= lvl_r);

  // per-axis distance operand, sign-extended compares
  assign e_x     = {first_r[ax_r][COORD_W-1], first_r[ax_r]};
  assign f_x     = e_x;
  assign s_x     = {second_r[ax_r][COORD_W-1], second_r[ax_r]};
  assign lo_x    = {low_q[COORD_W-1], low_q};
  assign hi_x    = {high_q[COORD_W-1], high_q};
  assign below_d = lo_x - e_x;
  assign above_d = e_x - hi_x;
  assign org_fs  = f_x - s_x;
  assign org_sf  = s_x - f_x;

  always_comb begin
    diff_op = '0;
    if (origin_r) begin
      diff_op = org_fs[COORD_W] ? org_sf[COORD_W-1:0] : org_fs[COORD_W-1:0];
    end else if (!below_d[COORD_W] && (below_d != '0)) begin
      // eye below the low corner
      diff_op = below_d[COORD_W-1:0];
    end else if (!above_d[COORD_W] && (above_d != '0)) begin
      // eye above the high corner
      diff_op = above_d[COORD_W-1:0];
    end
  end

  // the one shared multiplier
  assign sq = op_r * op_r;

  assign aq = SCALE_W'(acc_r);
  assign tq = SCALE_W'(prod_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_SELECT) begin
            state_nxt = ((n_lvl == '0) || (lim == '0)) ? ST_IDLE : ST_DIFF;
          end else begin
            state_nxt = in_box_present ? ST_WRITE : ST_IDLE;
          end
        end
      end
      ST_WRITE:  state_nxt = last_ax ? ST_IDLE : ST_WRITE;
      ST_READ:   state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ACC;
      ST_ACC: begin
        if (last_ax) begin
          state_nxt = origin_r ? ST_LEVEL : ST_THRESH;
        end else begin
          state_nxt = origin_r ? ST_DIFF : ST_READ;
        end
      end
      ST_LEVEL:  state_nxt = box_valid_r[lvl_r] ? ST_READ : ST_THRESH;
      ST_THRESH: state_nxt = ST_TMUL;
      ST_TMUL:   state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_CMP;
      ST_CMP:    state_nxt = (pass || lvl_last) ? ST_IDLE : ST_LEVEL;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    level_count_nxt     = level_count_r;
    threshold_count_nxt = threshold_count_r;
    thr_nxt             = thr_r;
    box_valid_nxt       = box_valid_r;
    last_level_nxt      = last_level_r;
    last_valid_nxt      = last_valid_r;
    out_valid_nxt       = 1'b0;
    ax_nxt              = ax_r;
    lvl_nxt             = lvl_r;
    origin_nxt          = origin_r;
    first_nxt           = first_r;
    second_nxt          = second_r;
    wr_level_nxt        = wr_level_r;
    op_nxt              = op_r;
    prod_nxt            = prod_r;
    acc_nxt             = acc_r;
    d_origin_nxt        = d_origin_r;
    lhs_nxt             = lhs_r;
    rhs_nxt             = rhs_r;
    out_level_nxt       = out_level_r;
    out_none_nxt        = out_none_r;

    // configuration writes, to be made only while idle; the block does not enforce it
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL_COUNT:     level_count_nxt     = cfg_data[CNT_W-1:0];
        REG_THRESHOLD_COUNT: threshold_count_nxt = cfg_data[CNT_W-1:0];
        REG_THRESHOLD_ZERO:  thr_nxt[0]          = cfg_data[THR_W-1:0];
        REG_THRESHOLD_ONE:   thr_nxt[1]          = cfg_data[THR_W-1:0];
        REG_THRESHOLD_TWO:   thr_nxt[2]          = cfg_data[THR_W-1:0];
        REG_THRESHOLD_THREE: thr_nxt[3]          = cfg_data[THR_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          first_nxt[0]  = in_first_x;
          first_nxt[1]  = in_first_y;
          first_nxt[2]  = in_first_z;
          second_nxt[0] = in_second_x;
          second_nxt[1] = in_second_y;
          second_nxt[2] = in_second_z;
          wr_level_nxt  = in_level_index;
          ax_nxt        = '0;
          acc_nxt       = '0;
          lvl_nxt       = '0;
          origin_nxt    = 1'b1;
          if (in_action == ACT_SELECT) begin
            if (n_lvl == '0) begin
              // no levels: report none and forget the previous choice
              out_valid_nxt  = 1'b1;
              out_level_nxt  = '0;
              out_none_nxt   = 1'b1;
              last_valid_nxt = 1'b0;
            end else if (lim == '0) begin
              // nothing to test, fall back to the last level
              out_valid_nxt  = 1'b1;
              out_level_nxt  = last_idx;
              out_none_nxt   = 1'b0;
              last_level_nxt = last_idx;
              last_valid_nxt = 1'b1;
            end
          end else begin
            box_valid_nxt[in_level_index] = in_box_present;
          end
        end
      end
      ST_WRITE: begin
        ax_nxt = ax_r + AXIS_W'(1);
      end
      ST_DIFF: begin
        op_nxt = diff_op;
      end
      ST_MUL, ST_TMUL: begin
        prod_nxt = sq;
      end
      ST_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
        if (last_ax) begin
          ax_nxt = '0;
          if (origin_r) begin
            d_origin_nxt = acc_r + ACC_W'(prod_r);
            origin_nxt   = 1'b0;
          end
        end else begin
          ax_nxt = ax_r + AXIS_W'(1);
        end
      end
      ST_LEVEL: begin
        ax_nxt  = '0;
        acc_nxt = box_valid_r[lvl_r] ? '0 : d_origin_r;
      end
      ST_THRESH: begin
        op_nxt = COORD_W'(thr_r[lvl_r]);
      end
      ST_SCALE: begin
        // 100 * d2 against 121 * t2 (widened) or 81 * t2 (narrowed)
        lhs_nxt = (aq << 6) + (aq << 5) + (aq << 2);
        rhs_nxt = widen ? (tq << 7) - (tq << 3) + tq
                        : (tq << 6) + (tq << 4) + tq;
      end
      ST_CMP: begin
        if (pass || lvl_last) begin
          out_valid_nxt  = 1'b1;
          out_none_nxt   = 1'b0;
          out_level_nxt  = pass ? lvl_r : last_idx;
          last_level_nxt = pass ? lvl_r : last_idx;
          last_valid_nxt = 1'b1;
        end else begin
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      level_count_r     <= '0;
      threshold_count_r <= '0;
      for (int i = 0; i < MAX_THRESH; i++) begin
        thr_r[i] <= '0;
      end
      box_valid_r       <= '0;
      last_level_r      <= '0;
      last_valid_r      <= 1'b0;
      out_valid_r       <= 1'b0;
      ax_r              <= '0;
      lvl_r             <= '0;
      origin_r          <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      level_count_r     <= level_count_nxt;
      threshold_count_r <= threshold_count_nxt;
      thr_r             <= thr_nxt;
      box_valid_r       <= box_valid_nxt;
      last_level_r      <= last_level_nxt;
      last_valid_r      <= last_valid_nxt;
      out_valid_r       <= out_valid_nxt;
      ax_r              <= ax_nxt;
      lvl_r             <= lvl_nxt;
      origin_r          <= origin_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    second_r    <= second_nxt;
    wr_level_r  <= wr_level_nxt;
    op_r        <= op_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    d_origin_r  <= d_origin_nxt;
    lhs_r       <= lhs_nxt;
    rhs_r       <= rhs_nxt;
    out_level_r <= out_level_nxt;
    out_none_r  <= out_none_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_level = out_level_r;
  assign out_none_chosen  = out_none_r;

endmodule

// ===== tb/lod_level_select_hysteresis_unit_tb.sv =====
`timescale 1ns / 100ps

module lod_level_select_hysteresis_unit_tb
  import lodsel_pkg::*;
();

  // clocking and run length
  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 10;
  localparam int LATENCY_CYCLES = 100;    // room for the slowest select plus the strobe
  localparam int DRAIN_LIMIT    = 4000;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int MAX_GAP        = 14;
  localparam int RANDOM_WORDS   = 700;
  localparam int RANDOM_PHASES  = 10;

  // register indexes the block does not decode
  localparam cfg_idx_t REG_UNUSED_SIX   = cfg_idx_t'(6);
  localparam cfg_idx_t REG_UNUSED_SEVEN = cfg_idx_t'(7);

  typedef logic [79:0]                      dist_t;   // squared distances, scaled
  typedef logic [COORD_W-1:0]               coord_t;
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] point_t;  // index 0 is x

  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct packed {
    logic             action;
    logic [LVL_W-1:0] level;
    logic             present;
    point_t           first;
    point_t           second;
  } lod_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             none;
  } lod_choice_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_action;
  logic [LVL_W-1:0]          in_level_index;
  logic                      in_box_present;
  logic signed [COORD_W-1:0] in_first_x;
  logic signed [COORD_W-1:0] in_first_y;
  logic signed [COORD_W-1:0] in_first_z;
  logic signed [COORD_W-1:0] in_second_x;
  logic signed [COORD_W-1:0] in_second_y;
  logic signed [COORD_W-1:0] in_second_z;
  logic                      out_valid;
  logic [LVL_W-1:0]          out_chosen_level;
  logic                      out_none_chosen;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  lod_level_select_hysteresis_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_level_index   (in_level_index),
    .in_box_present   (in_box_present),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_first_z       (in_first_z),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_second_z      (in_second_z),
    .out_valid        (out_valid),
    .out_chosen_level (out_chosen_level),
    .out_none_chosen  (out_none_chosen),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // choices still owed by the block, oldest first
  lod_choice_t pending_choices[$];
  int          mismatch_count = 0;
  bit          no_gaps = 0;     // set for stretches with back-to-back words

  // shadow of the block: configuration
  logic [CNT_W-1:0] level_count_q;
  logic [CNT_W-1:0] thresh_count_q;
  logic [THR_W-1:0] thresh_q [MAX_THRESH];

  // shadow of the block: box table (order-preserving form) and last choice
  coord_t           box_lo [MAX_LEVELS][NUM_AXES];
  coord_t           box_hi [MAX_LEVELS][NUM_AXES];
  logic             box_ok [MAX_LEVELS];
  logic [LVL_W-1:0] prev_level;
  logic             prev_valid;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // flipping the sign bit turns signed order into unsigned order
  function automatic coord_t to_ordered(coord_t v);
    return v ^ COORD_MIN;
  endfunction

  function automatic dist_t square(coord_t d);
    dist_t w;
    w = dist_t'(d);
    return w * w;
  endfunction

  // a value within +/- 2^scale, or anything at all from scale 31 up
  function automatic coord_t rand_coord(int scale);
    if (scale >= COORD_W - 1) return coord_t'($urandom);
    return coord_t'($urandom_range(0, (2 << scale) - 1)) - (coord_t'(1) << scale);
  endfunction

  function automatic point_t rand_point(int scale);
    point_t p;
    for (int a = 0; a < NUM_AXES; a++) p[a] = rand_coord(scale);
    return p;
  endfunction

  function automatic logic [THR_W-1:0] rand_thresh(int scale);
    if (scale >= THR_W) return THR_W'($urandom);
    return THR_W'($urandom_range(0, 2 << scale));
  endfunction

  function automatic lod_word_t box_word(logic [LVL_W-1:0] lvl, logic present,
                                         point_t lo, point_t hi);
    lod_word_t w;
    w.action  = ACT_WRITE;
    w.level   = lvl;
    w.present = present;
    w.first   = lo;
    w.second  = hi;
    return w;
  endfunction

  // level and box fields are ignored on a select, so they carry noise
  function automatic lod_word_t view_word(point_t eye, point_t origin);
    lod_word_t w;
    w.action  = ACT_SELECT;
    w.level   = LVL_W'($urandom);
    w.present = 1'($urandom);
    w.first   = eye;
    w.second  = origin;
    return w;
  endfunction

  task automatic reset_shadow();
    level_count_q  = '0;
    thresh_count_q = '0;
    for (int i = 0; i < MAX_THRESH; i++) thresh_q[i] = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      box_ok[i] = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        box_lo[i][a] = '0;
        box_hi[i][a] = '0;
      end
    end
    prev_level = '0;
    prev_valid = 1'b0;
  endtask

  task automatic apply_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LEVEL_COUNT:     level_count_q  = data[CNT_W-1:0];
      REG_THRESHOLD_COUNT: thresh_count_q = data[CNT_W-1:0];
      REG_THRESHOLD_ZERO:  thresh_q[0]    = data[THR_W-1:0];
      REG_THRESHOLD_ONE:   thresh_q[1]    = data[THR_W-1:0];
      REG_THRESHOLD_TWO:   thresh_q[2]    = data[THR_W-1:0];
      REG_THRESHOLD_THREE: thresh_q[3]    = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // updates the shadow for one accepted word and queues the choice a select owes
  task automatic predict_lod_choice(lod_word_t w);
    coord_t      eye [NUM_AXES];
    coord_t      origin [NUM_AXES];
    coord_t      d;
    dist_t       d_origin;
    dist_t       d2;
    dist_t       lhs;
    dist_t       rhs;
    int          n;
    int          lim;
    int          chosen;
    logic        passed;
    lod_choice_t res;

    for (int a = 0; a < NUM_AXES; a++) begin
      eye[a]    = to_ordered(w.first[a]);
      origin[a] = to_ordered(w.second[a]);
    end

    if (w.action == ACT_WRITE) begin
      if (w.present) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          box_lo[w.level][a] = eye[a];
          box_hi[w.level][a] = origin[a];
        end
        box_ok[w.level] = 1'b1;
      end else begin
        box_ok[w.level] = 1'b0;   // corners kept, mark cleared
      end
      return;
    end

    n = (level_count_q > MAX_LEVELS) ? MAX_LEVELS : int'(level_count_q);
    if (n == 0) begin
      // nothing to pick, and the last choice is forgotten
      prev_valid = 1'b0;
      res.level  = '0;
      res.none   = 1'b1;
      pending_choices = {pending_choices, res};
      return;
    end

    d_origin = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      d = (eye[a] > origin[a]) ? eye[a] - origin[a] : origin[a] - eye[a];
      d_origin += square(d);
    end

    lim = (thresh_count_q > MAX_THRESH) ? MAX_THRESH : int'(thresh_count_q);
    if (lim > n) lim = n;
    chosen = n - 1;
    passed = 1'b0;
    for (int i = 0; i < lim && !passed; i++) begin
      if (box_ok[i]) begin
        // distance to the box, per axis clamped to the nearer face
        d2 = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
          if (eye[a] < box_lo[i][a])      d = box_lo[i][a] - eye[a];
          else if (eye[a] > box_hi[i][a]) d = eye[a] - box_hi[i][a];
          else                            d = '0;
          d2 += square(d);
        end
      end else begin
        d2 = d_origin;
      end
      // widened by 11/10 at or above the last choice, narrowed by 9/10 below it
      lhs = d2 * dist_t'(100);
      rhs = square(coord_t'(thresh_q[i])) *
            dist_t'((prev_valid && prev_level <= i) ? 121 : 81);
      if (lhs <= rhs) begin
        chosen = i;
        passed = 1'b1;
      end
    end

    prev_level = chosen[LVL_W-1:0];
    prev_valid = 1'b1;
    res.level  = chosen[LVL_W-1:0];
    res.none   = 1'b0;
    pending_choices = {pending_choices, res};
  endtask

  // one word on the command channel, after a random hold-off
  task automatic send_word(lod_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action      <= w.action;
    in_level_index <= w.level;
    in_box_present <= w.present;
    in_first_x     <= w.first[0];
    in_first_y     <= w.first[1];
    in_first_z     <= w.first[2];
    in_second_x    <= w.second[0];
    in_second_y    <= w.second[1];
    in_second_z    <= w.second[2];
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    predict_lod_choice(w);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, collect every owed choice, then let a last box write finish
  task automatic settle_block();
    int waited;
    @(negedge clk);
    start  <= 1'b0;
    waited = 0;
    while (pending_choices.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_choices.size() != 0) begin
      $error("%0d choice words never arrived", pending_choices.size());
      mismatch_count += pending_choices.size();
      pending_choices.delete();
    end
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // reset state: no levels, so a select reports none
  task automatic test_no_levels();
    send_word(view_word(rand_point(10), rand_point(10)));
  endtask

  // coordinates and thresholds at their limits, full and inverted boxes
  task automatic test_field_extremes();
    settle_block();
    write_register(REG_LEVEL_COUNT, CFG_DATA_W'(4));
    write_register(REG_THRESHOLD_COUNT, CFG_DATA_W'(4));
    write_register(REG_THRESHOLD_ZERO, '0);
    write_register(REG_THRESHOLD_ONE, THR_MAX);
    write_register(REG_THRESHOLD_TWO, CFG_DATA_W'(1));
    write_register(REG_THRESHOLD_THREE, THR_MAX);
    // box spanning all space: any eye is inside, distance zero
    send_word(box_word(LVL_W'(0), 1'b1, {3{COORD_MIN}}, {3{COORD_MAX}}));
    send_word(view_word({3{COORD_MIN}}, {3{COORD_MAX}}));
    send_word(view_word({3{COORD_MAX}}, {3{COORD_MIN}}));
    // mark cleared: falls back to the widest possible origin distance
    send_word(box_word(LVL_W'(0), 1'b0, {3{COORD_MAX}}, {3{COORD_MIN}}));
    send_word(view_word({3{COORD_MIN}}, {3{COORD_MAX}}));
    // inverted box on level 1, and a point box on level 3
    send_word(box_word(LVL_W'(1), 1'b1, {3{COORD_MAX}}, {3{COORD_MIN}}));
    send_word(box_word(LVL_W'(3), 1'b1, '0, '0));
    send_word(view_word('0, '0));
    send_word(view_word('0, {3{COORD_MIN}}));
  endtask

  // switch distance widened above and narrowed below the last choice
  task automatic test_hysteresis();
    settle_block();
    write_register(REG_LEVEL_COUNT, '0);
    send_word(view_word('0, '0));   // forgets the last choice
    settle_block();
    write_register(REG_LEVEL_COUNT, CFG_DATA_W'(2));
    write_register(REG_THRESHOLD_COUNT, CFG_DATA_W'(2));
    write_register(REG_THRESHOLD_ZERO, CFG_DATA_W'(1000));
    write_register(REG_THRESHOLD_ONE, CFG_DATA_W'(400));
    for (int i = 0; i < MAX_LEVELS; i++) send_word(box_word(LVL_W'(i), 1'b0, '0, '0));
    // eye on the x axis, origin at zero: 900 and 1100 sit on the edges
    send_word(view_word(point_t'(coord_t'(950)), '0));
    send_word(view_word(point_t'(coord_t'(900)), '0));
    send_word(view_word(point_t'(coord_t'(1100)), '0));
    send_word(view_word(point_t'(coord_t'(1101)), '0));
    send_word(view_word(point_t'(coord_t'(-1050)), '0));
    send_word(view_word(point_t'(coord_t'(899)), '0));
  endtask

  // counts beyond the table are clamped, unknown indexes are dropped
  task automatic test_count_clamp();
    settle_block();
    write_register(REG_LEVEL_COUNT, THR_MAX);                  // low bits 7
    write_register(REG_THRESHOLD_COUNT, {28'hABCDEF0, 3'd5});
    write_register(REG_THRESHOLD_ZERO, '0);
    write_register(REG_THRESHOLD_ONE, '0);
    write_register(REG_THRESHOLD_TWO, '0);
    write_register(REG_THRESHOLD_THREE, THR_MAX);
    write_register(REG_UNUSED_SIX, CFG_DATA_W'($urandom));
    write_register(REG_UNUSED_SEVEN, CFG_DATA_W'($urandom));
    send_word(view_word(rand_point(12), rand_point(12)));
    settle_block();
    write_register(REG_THRESHOLD_COUNT, '0);                   // last level by default
    send_word(view_word(rand_point(12), rand_point(12)));
    settle_block();
    write_register(REG_LEVEL_COUNT, CFG_DATA_W'(1));
    write_register(REG_THRESHOLD_COUNT, CFG_DATA_W'(6));
    send_word(view_word(rand_point(4), rand_point(4)));
  endtask

  // random settings per phase, then box writes and selects at one scale
  task automatic test_random_traffic();
    int               scale;
    int               per_phase;
    logic [CNT_W-1:0] pick;
    point_t           lo;

    per_phase = RANDOM_WORDS / RANDOM_PHASES;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      no_gaps = (phase % 4 == 3);
      case (phase % 5)
        0:       scale = 6;
        1:       scale = 12;
        2:       scale = 20;
        3:       scale = 31;
        default: scale = 16;
      endcase

      // mostly counts of one to four, sometimes any value the field holds
      pick = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(1, 4)) : CNT_W'($urandom);
      write_register(REG_LEVEL_COUNT, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(7)) | pick);
      pick = ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(1, 4)) : CNT_W'($urandom);
      write_register(REG_THRESHOLD_COUNT,
                     (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(7)) | pick);
      if (phase == RANDOM_PHASES - 1) begin
        write_register(REG_THRESHOLD_ZERO, THR_MAX);
        write_register(REG_THRESHOLD_ONE, '0);
      end else begin
        write_register(REG_THRESHOLD_ZERO, rand_thresh(scale + 1));
        write_register(REG_THRESHOLD_ONE, rand_thresh(scale + 1));
      end
      write_register(REG_THRESHOLD_TWO, rand_thresh(scale + 1));
      write_register(REG_THRESHOLD_THREE, rand_thresh(scale + 1));
      if ($urandom_range(0, 2) == 0)
        write_register($urandom_range(0, 1) ? REG_UNUSED_SIX : REG_UNUSED_SEVEN,
                       CFG_DATA_W'($urandom));

      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          // boxes mostly well ordered, some inverted
          lo = rand_point(scale);
          if ($urandom_range(0, 3) == 0)
            send_word(box_word(LVL_W'($urandom), $urandom_range(0, 4) != 0, lo,
                               rand_point(scale)));
          else
            send_word(box_word(LVL_W'($urandom), $urandom_range(0, 4) != 0, lo,
                               lo + point_t'({3{coord_t'($urandom_range(0, 2 << scale))}})));
        end else begin
          send_word(view_word(rand_point(scale), rand_point(scale)));
        end
      end
    end
    no_gaps = 0;
  endtask

  // each choice word is taken at the edge that ends its strobe cycle
  always @(posedge clk) begin : check_choice
    lod_choice_t want;
    if (rst_n && out_valid) begin
      if (pending_choices.size() == 0) begin
        $error("choice word with none owed: chosen_level %0d none_chosen %0b",
               out_chosen_level, out_none_chosen);
        mismatch_count++;
      end else begin
        want = pending_choices.pop_front();
        if (out_chosen_level !== want.level) begin
          $error("chosen_level: expected %0d, actual %0d", want.level, out_chosen_level);
          mismatch_count++;
        end
        if (out_none_chosen !== want.none) begin
          $error("none_chosen: expected %0b, actual %0b", want.none, out_none_chosen);
          mismatch_count++;
        end
      end
    end
  end

  // hang guard, far above the slowest correct run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = ACT_WRITE;
    in_level_index = '0;
    in_box_present = 1'b0;
    in_first_x     = '0;
    in_first_y     = '0;
    in_first_z     = '0;
    in_second_x    = '0;
    in_second_y    = '0;
    in_second_z    = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_no_levels();
    test_field_extremes();
    test_hysteresis();
    test_count_clamp();
    test_random_traffic();
    settle_block();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
